/* hdl/wadl_pkg.sv */
// ----------------------------------------------------------------------------
// wadl_pkg: shared types and constants
// Modulus and the per-stage request records passed between the pipeline
// stages of the word Adler checksum.
// ----------------------------------------------------------------------------
package wadl_pkg;

   // Adler modulus and word geometry
   localparam logic [15:0] ADLER_MOD  = 16'd65521;
   localparam int unsigned WORD_BITS  = 64;
   localparam int unsigned WORD_BYTES = WORD_BITS / 8;

   // Masked word as it leaves the input stage
   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic                 nonzero;
      logic                 last;
   } wadl_word_type;

   // Word reduced modulo ADLER_MOD
   typedef struct packed {
      logic [15:0] resid;
      logic        nonzero;
      logic        last;
   } wadl_resid_type;

endpackage

/* hdl/wadl_skid_mask.sv */
// ----------------------------------------------------------------------------
// wadl_skid_mask: input skid buffer and byte mask stage
// Takes requests behind a registered stall, clears bytes above the valid
// count and loads the first pipeline register.
// ----------------------------------------------------------------------------
module wadl_skid_mask (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [63:0]            req_data_word,
   input  logic [3:0]             req_valid_bytes,
   input  logic                   req_last,
   output logic                   req_stall,
   input  logic                   adv,
   output logic                   s1_valid,
   output wadl_pkg::wadl_word_type s1
);

   logic                    skid_valid_ff;
   logic [63:0]             skid_word_ff;
   logic [3:0]              skid_bytes_ff;
   logic                    skid_last_ff;
   logic                    s1_valid_ff;
   wadl_pkg::wadl_word_type s1_ff;
   wadl_pkg::wadl_word_type s1_in;
   logic                    accept;
   logic                    src_valid;
   logic [63:0]             src_word;
   logic [3:0]              src_bytes;
   logic                    src_last;

   // Take a request only while the skid slot is free
   assign accept    = req_valid && !skid_valid_ff;
   assign src_valid = skid_valid_ff || accept;
   assign src_word  = skid_valid_ff ? skid_word_ff  : req_data_word;
   assign src_bytes = skid_valid_ff ? skid_bytes_ff : req_valid_bytes;
   assign src_last  = skid_valid_ff ? skid_last_ff  : req_last;

   // Drop the bytes above the valid count; counts of eight and above keep all
   always_comb begin
      for (int i = 0; i < wadl_pkg::WORD_BYTES; i++) begin
         s1_in.word[8*i +: 8] = (src_bytes > 4'(i)) ? src_word[8*i +: 8] : 8'd0;
      end
      s1_in.nonzero = (src_bytes != 4'd0);
      s1_in.last    = src_last;
   end

   // Control: advance the stage, or park the request in the skid slot
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
      end else if (adv) begin
         skid_valid_ff <= 1'b0;
         s1_valid_ff   <= src_valid;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
      end
      if (!adv && accept) begin
         skid_word_ff  <= req_data_word;
         skid_bytes_ff <= req_valid_bytes;
         skid_last_ff  <= req_last;
      end
   end

   assign req_stall = skid_valid_ff;
   assign s1_valid  = s1_valid_ff;
   assign s1        = s1_ff;

endmodule

/* hdl/wadl_mod_reduce.sv */
// ----------------------------------------------------------------------------
// wadl_mod_reduce: 64-bit word modulo 65521
// Two stages: weigh the four 16-bit chunks by powers of 15 (2^16 mod 65521),
// then fold the 28-bit total twice and subtract the modulus once.
// ----------------------------------------------------------------------------
module wadl_mod_reduce (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    s1_valid,
   input  wadl_pkg::wadl_word_type s1,
   output logic                    s3_valid,
   output wadl_pkg::wadl_resid_type s3
);

   logic                     s2_valid_ff;
   logic [27:0]              s2_sum_ff;
   logic                     s2_nonzero_ff;
   logic                     s2_last_ff;
   logic [27:0]              s2_sum_in;
   logic                     s3_valid_ff;
   wadl_pkg::wadl_resid_type s3_ff;
   wadl_pkg::wadl_resid_type s3_in;
   logic [16:0]              fold1;
   logic [16:0]              fold2;

   // Weigh chunks: 1, 15, 225, 3375 are 2^(16k) mod 65521
   assign s2_sum_in = 28'(s1.word[15:0])
                    + 28'(s1.word[31:16]) * 28'd15
                    + 28'(s1.word[47:32]) * 28'd225
                    + 28'(s1.word[63:48]) * 28'd3375;

   // Fold twice, then one conditional subtract
   always_comb begin
      fold1         = 17'(s2_sum_ff[15:0]) + 17'(s2_sum_ff[27:16]) * 17'd15;
      fold2         = 17'(fold1[15:0]) + (fold1[16] ? 17'd15 : 17'd0);
      s3_in.resid   = (fold2 >= 17'(wadl_pkg::ADLER_MOD))
                    ? 16'(fold2 - 17'(wadl_pkg::ADLER_MOD)) : fold2[15:0];
      s3_in.nonzero = s2_nonzero_ff;
      s3_in.last    = s2_last_ff;
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_sum_ff     <= s2_sum_in;
         s2_nonzero_ff <= s1.nonzero;
         s2_last_ff    <= s1.last;
         s3_ff         <= s3_in;
      end
   end

   assign s3_valid = s3_valid_ff;
   assign s3       = s3_ff;

endmodule

/* hdl/wadl_accum.sv */
// ----------------------------------------------------------------------------
// wadl_accum: running sums and result register
// Updates sums A and B modulo 65521 per word, emits (B<<16)|A on the last
// word of a message and restarts the sums.
// ----------------------------------------------------------------------------
module wadl_accum (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     s3_valid,
   input  wadl_pkg::wadl_resid_type s3,
   output logic                     adv,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [31:0]              rsp_checksum
);

   logic [15:0] sum_a_ff;
   logic [15:0] sum_b_ff;
   logic [15:0] sum_a_in;
   logic [15:0] sum_b_in;
   logic        rsp_valid_ff;
   logic [31:0] rsp_checksum_ff;
   logic [16:0] a_wide;
   logic [16:0] b_wide;

   // Advance the pipeline whenever the result register is free or draining
   assign adv = !rsp_valid_ff || !rsp_stall;

   // Add the word to A, then A to B; an empty word leaves both alone
   always_comb begin
      a_wide   = 17'(sum_a_ff) + 17'(s3.resid);
      sum_a_in = (a_wide >= 17'(wadl_pkg::ADLER_MOD))
               ? 16'(a_wide - 17'(wadl_pkg::ADLER_MOD)) : a_wide[15:0];
      b_wide   = 17'(sum_b_ff) + 17'(sum_a_in);
      sum_b_in = (b_wide >= 17'(wadl_pkg::ADLER_MOD))
               ? 16'(b_wide - 17'(wadl_pkg::ADLER_MOD)) : b_wide[15:0];
      if (!s3.nonzero) begin
         sum_a_in = sum_a_ff;
         sum_b_in = sum_b_ff;
      end
   end

   // Sums and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff     <= 16'd1;
         sum_b_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s3_valid && s3.last;
         if (s3_valid && s3.last) begin
            sum_a_ff <= 16'd1;
            sum_b_ff <= 16'd0;
         end else if (s3_valid) begin
            sum_a_ff <= sum_a_in;
            sum_b_ff <= sum_b_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (adv && s3_valid && s3.last) begin
         rsp_checksum_ff <= {sum_b_in, sum_a_in};
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = rsp_checksum_ff;

endmodule

/* hdl/word_adler_checksum_top.sv */
// ----------------------------------------------------------------------------
// word_adler_checksum_top: Adler-style checksum over 64-bit words
// Path: an accepted request is masked into the input register, then passes the weigh,
// fold and accumulate registers to result valid; a result stall holds it back.
// Throughput: one word per cycle when results are not stalled; a request parked
// in the skid slot during a result stall holds off new requests as it drains.
// Reset: synchronous; clears pipeline valids and skid slot, A=1, B=0.
// ----------------------------------------------------------------------------
module word_adler_checksum_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_checksum
);

   logic                     adv;
   logic                     s1_valid;
   wadl_pkg::wadl_word_type  s1;
   logic                     s3_valid;
   wadl_pkg::wadl_resid_type s3;

   // Input skid and byte mask
   wadl_skid_mask u_skid_mask (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_last        (req_last),
      .req_stall       (req_stall),
      .adv             (adv),
      .s1_valid        (s1_valid),
      .s1              (s1)
   );

   // Modular reduction of the word
   wadl_mod_reduce u_mod_reduce (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .s1_valid (s1_valid),
      .s1       (s1),
      .s3_valid (s3_valid),
      .s3       (s3)
   );

   // Running sums and result
   wadl_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .s3_valid     (s3_valid),
      .s3           (s3),
      .adv          (adv),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_checksum (rsp_checksum)
   );

endmodule

/* hdl/wadl_checker.sv */
// ----------------------------------------------------------------------------
// wadl_checker: port-level checks for the word Adler checksum
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module wadl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_checksum
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_checksum))
      else $error("stalled result changed");

   // Both halves of a result are reduced below the modulus
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_checksum[15:0] < 16'd65521) && (rsp_checksum[31:16] < 16'd65521))
      else $error("checksum half not reduced");

   // Reset empties the result register
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Reset empties the skid slot
   a_reset_stall: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("request stall after reset");

   // The skid slot fills, and the stall rises, only behind a presented request
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_stall && !req_valid |=> !req_stall)
      else $error("stall raised without a request");

endmodule

bind word_adler_checksum_top wadl_checker u_wadl_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_checksum (rsp_checksum)
);

/* tb/tb_word_adler_checksum_top.sv */
// ----------------------------------------------------------------------------
// tb_word_adler_checksum_top: self-checking bench for the word Adler checksum
// Feeds messages of 64-bit words through the request channel with random
// gaps and result stalls, predicts each checksum with running A/B sums
// modulo 65521, and compares every result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_word_adler_checksum_top;

   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
   } word_req_type;

   localparam int unsigned RANDOM_REQS = 950;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_data_word = '0;
   logic [3:0]  req_valid_bytes = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_checksum;

   // requests waiting to be driven and checksums waiting to come out
   word_req_type pending_reqs[$];
   logic [31:0]  checksum_q[$];

   // running sums of the message in flight
   logic [15:0] run_a = 16'd1;
   logic [15:0] run_b = 16'd0;

   int unsigned accepted_reqs = 0;
   int unsigned short_reqs    = 0;
   int unsigned messages_sent = 0;
   int unsigned checksums_ok  = 0;
   int unsigned errors        = 0;

   word_req_type next_req;
   logic [31:0]  want_sum;

   word_adler_checksum_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_checksum    (rsp_checksum)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // print one mismatch line and count it
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t: %s: got %08h, expected %08h", $time, what, got, want);
      errors++;
   endtask

   // fold one accepted request into the running sums; close the message on last
   task automatic absorb_request(input logic [63:0] word, input logic [3:0] nbytes,
                                 input logic last);
      logic [63:0] masked;
      int unsigned resid;
      int unsigned a_next;
      int unsigned b_next;
      if (nbytes != 4'd0) begin
         masked = word;
         if (nbytes < 4'd8) begin
            masked = word & ((64'd1 << (8 * nbytes)) - 64'd1);
         end
         resid  = int'(masked % 64'(wadl_pkg::ADLER_MOD));
         a_next = (int'(run_a) + resid) % int'(wadl_pkg::ADLER_MOD);
         b_next = (int'(run_b) + a_next) % int'(wadl_pkg::ADLER_MOD);
         run_a  = a_next[15:0];
         run_b  = b_next[15:0];
      end
      if (nbytes < 4'd8) begin
         short_reqs++;
      end
      if (last) begin
         checksum_q.push_back({run_b, run_a});
         run_a = 16'd1;
         run_b = 16'd0;
      end
   endtask

   // no idling on either side for a stretch in the middle of the run
   function automatic bit steady_stretch();
      return accepted_reqs >= 300 && accepted_reqs < 520;
   endfunction

   function automatic logic [63:0] pick_word();
      case ($urandom_range(7))
         0: return 64'd0;
         1: return '1;
         2: return 64'd1 << $urandom_range(63);
         3: return 64'(wadl_pkg::ADLER_MOD) * $urandom_range(3) + $urandom_range(2) - 64'd1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic queue_req(input logic [63:0] word, input logic [3:0] nbytes,
                            input logic last);
      pending_reqs.push_back('{word: word, nbytes: nbytes, last: last});
   endtask

   // driver: present requests, hold a stalled one, idle at random
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_request(req_data_word, req_valid_bytes, req_last);
            accepted_reqs++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 &&
                (steady_stretch() || $urandom_range(99) >= 33)) begin
               next_req = pending_reqs.pop_front();
               req_valid       <= 1'b1;
               req_data_word   <= next_req.word;
               req_valid_bytes <= next_req.nbytes;
               req_last        <= next_req.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each accepted checksum, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (checksum_q.size() == 0) begin
               report_mismatch("checksum with no request behind it", rsp_checksum, '0);
            end else begin
               want_sum = checksum_q.pop_front();
               if (rsp_checksum !== want_sum) begin
                  report_mismatch("checksum", rsp_checksum, want_sum);
               end else begin
                  checksums_ok++;
               end
            end
         end
         rsp_stall <= !steady_stretch() && ($urandom_range(99) < 33);
      end
   end

   // stimulus and end of run
   initial begin
      int unsigned n_random;
      int unsigned len;
      int unsigned total_reqs;
      bit          noisy;

      // empty message, then single full words
      queue_req('0, 4'd0, 1'b1);
      queue_req('1, 4'd8, 1'b1);
      queue_req('0, 4'd8, 1'b1);
      // partial final words of every length
      for (int nb = 1; nb < 8; nb++) begin
         queue_req('1, 4'(nb), 1'b1);
      end
      // oversized byte counts use the whole word
      queue_req({$urandom, $urandom}, 4'd9, 1'b0);
      queue_req({$urandom, $urandom}, 4'd10, 1'b0);
      queue_req('1, 4'd11, 1'b0);
      queue_req({$urandom, $urandom}, 4'd12, 1'b0);
      queue_req('1, 4'd15, 1'b1);
      // short and empty words before the end, then an empty last word
      queue_req('1, 4'd3, 1'b0);
      queue_req('1, 4'd0, 1'b0);
      queue_req(64'(wadl_pkg::ADLER_MOD), 4'd8, 1'b0);
      queue_req('1, 4'd0, 1'b1);
      // words at the modulus edge
      queue_req(64'(wadl_pkg::ADLER_MOD) - 64'd1, 4'd8, 1'b0);
      queue_req(64'h8000_0000_0000_0000, 4'd14, 1'b1);
      queue_req(64'h7fff_ffff_ffff_ffff, 4'd13, 1'b1);
      messages_sent = 14;

      // random messages: mostly well formed, some with odd byte counts
      n_random = 0;
      while (n_random < RANDOM_REQS) begin
         noisy = $urandom_range(99) < 15;
         len   = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
         for (int unsigned i = 1; i <= len; i++) begin
            if (noisy) begin
               queue_req(pick_word(), 4'($urandom_range(15)), i == len);
            end else if (i == len) begin
               queue_req(pick_word(), 4'($urandom_range(8)), 1'b1);
            end else begin
               queue_req(pick_word(), 4'd8, 1'b0);
            end
         end
         n_random += len;
         messages_sent++;
      end
      total_reqs = pending_reqs.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // wait for every request to be taken, then every result, then settle
      while (accepted_reqs < total_reqs) begin
         @(posedge clock);
      end
      while (checksum_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      $display("Covered %0d requests in %0d messages, %0d of them short or empty words",
               accepted_reqs, messages_sent, short_reqs);
      $display("Matched %0d checksums, %0d mismatches", checksums_ok, errors);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Timeout: %0d checksums still outstanding", checksum_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
